FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the tag store RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tmts_pkg.sv
// Package for the two-level tag store: geometry constants, request codes,
// payload structs, controller state type and controller/datapath interface.
package tmts_pkg;

  localparam int PAGE_BYTES    = 4096;
  localparam int GRANULE_BYTES = 16;
  localparam int PAGE_COUNT    = 256;
  localparam int TAG_BITS      = 8;

  localparam int GRAN_SHIFT  = $clog2(GRANULE_BYTES);
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int GPP_W       = PAGE_SHIFT - GRAN_SHIFT;
  localparam int GRAN_PER_PG = 1 << GPP_W;
  localparam int PAGE_IDX_W  = $clog2(PAGE_COUNT);
  localparam int TOTAL_GRAN  = PAGE_COUNT * GRAN_PER_PG;
  localparam int GRAN_IDX_W  = $clog2(TOTAL_GRAN);
  localparam int GCNT_W      = $clog2(TOTAL_GRAN + 1);
  localparam int CNT_W       = 48;

  localparam logic [1:0] REQ_SET     = 2'd0;
  localparam logic [1:0] REQ_CHECK   = 2'd1;
  localparam logic [1:0] REQ_DROP    = 2'd2;
  localparam logic [1:0] REQ_CLR_CNT = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] addr;
    logic [23:0] range_size;
    logic [7:0]  tag;
  } in_req_t;

  typedef struct packed {
    logic              tag_match;
    logic [CNT_W-1:0]  access_count;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_CLEAR,
    ST_CHK,
    ST_CHK_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic drop;
    logic cnt_clr;
    logic clr_start;
    logic clr_step;
    logic set_write;
    logic chk_read;
    logic chk_direct;
    logic chk_cmp;
  } cmd_t;

  typedef struct packed {
    logic gran_done;
    logic page_present;
    logic clr_last;
    logic chk_hit;
  } status_t;

endpackage

FILE: rtl/core/two_level_memory_tag_store.sv
// Top level of the two-level granule tag store.
// Depends on tmts_pkg, tmts_ctrl, tmts_dp (with tmts_ram) and assert_macros.svh.
//
//  channel   ports                    handshake
//  --------  -----------------------  -------------------------------------------
//  request   in_req                   taken when start is high and busy is low
//  result    out_res                  out_valid high for one cycle, no backpressure
//
// A request is taken in the idle state; busy stays high until its result strobe.
// Clear counter and drop all pages go straight to the result strobe. A check of an
// absent or out-of-range page skips the tag RAM; a present page adds a registered
// tag RAM read. Set tags each granule in turn and first zeroes in full every page
// that it makes present (one tag RAM write port, one granule zeroed per cycle).
// Reset clears presence bits and the counter at once; the tag RAM is not cleared.
// The receiver cannot stall: each result is shown exactly once.
`include "assert_macros.svh"

module two_level_memory_tag_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tmts_pkg::in_req_t  in_req,
  output logic               out_valid,
  output tmts_pkg::out_res_t out_res
);
  import tmts_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each request: walk, clear pages, read, then strobe the result
  tmts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_req.req_type),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold request, presence bits, counter and tag RAM
  tmts_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .status  (status),
    .out_res (out_res)
  );

  `ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "request taken but block not busy")
  `ASSERT_NEXT(a_strobe_frees, out_valid, !busy && !out_valid, "block still busy after result")

endmodule

FILE: rtl/core/tmts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tmts_ctrl.sv
// Controller state machine of the tag store.
// Depends on tmts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  tmts_pkg::status_t  status,
  output tmts_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               out_valid
);
  import tmts_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_SET:   state_nxt = ST_SET;
            REQ_CHECK: state_nxt = ST_CHK;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SET: begin
        if (status.gran_done) begin
          state_nxt = ST_DONE;
        end else if (!status.page_present) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_nxt = ST_SET;
        end
      end
      ST_CHK: begin
        state_nxt = status.chk_hit ? ST_CHK_CMP : ST_DONE;
      end
      ST_CHK_CMP: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.drop    = (req_type == REQ_DROP);
          cmd.cnt_clr = (req_type == REQ_CLR_CNT);
        end
      end
      ST_SET: begin
        if (!status.gran_done) begin
          cmd.clr_start = !status.page_present;
          cmd.set_write = status.page_present;
        end
      end
      ST_CLEAR:   cmd.clr_step = 1'b1;
      ST_CHK: begin
        cmd.chk_read   = status.chk_hit;
        cmd.chk_direct = !status.chk_hit;
      end
      ST_CHK_CMP: cmd.chk_cmp = 1'b1;
      ST_DONE:    ;
      default:    ;
    endcase
  end

  `ASSERT_NEXT(a_done_single, state_r == ST_DONE, state_r == ST_IDLE, "result strobe held over")
  `ASSERT_ALWAYS(a_one_granule_op, $onehot0({cmd.set_write, cmd.clr_step, cmd.chk_read}), "granule port conflict")

endmodule

FILE: rtl/core/tmts_dp.sv
// Datapath of the tag store: request registers, range walker, page clear
// counter, presence bits, access counter and the granule tag RAM.
// Depends on tmts_pkg, tmts_ram and assert_macros.svh.
`include "assert_macros.svh"

module tmts_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tmts_pkg::in_req_t  in_req,
  input  tmts_pkg::cmd_t     cmd,
  output tmts_pkg::status_t  status,
  output tmts_pkg::out_res_t out_res
);
  import tmts_pkg::*;

  in_req_t                req_r;
  logic [GCNT_W-1:0]      gran_r, gran_nxt;
  logic [GCNT_W-1:0]      end_r;
  logic                   empty_r;
  logic [GPP_W-1:0]       clr_r;
  logic [PAGE_COUNT-1:0]  present_r;
  logic [CNT_W-1:0]       count_r;
  logic                   match_r;

  logic [32:0]            end_sum;
  logic [32:0]            end_full;
  logic [GCNT_W-1:0]      end_clamp;
  logic [31:0]            first_full;
  logic                   empty_nxt;
  logic [PAGE_IDX_W-1:0]  cur_page;
  logic [31-PAGE_SHIFT:0] chk_page_full;
  logic [PAGE_IDX_W-1:0]  chk_page;
  logic [GPP_W-1:0]       chk_offs;
  logic                   chk_oob;
  logic [TAG_BITS-1:0]    tag_w;
  logic                   ram_we;
  logic [GRAN_IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [TAG_BITS-1:0]    ram_wdata, ram_rdata;

  // Granule range of a set request, clamped to the end of the last page
  assign end_sum    = {1'b0, in_req.addr} + 33'(in_req.range_size) + 33'(GRANULE_BYTES - 1);
  assign end_full   = end_sum >> GRAN_SHIFT;
  assign end_clamp  = (end_full > 33'(TOTAL_GRAN)) ? GCNT_W'(TOTAL_GRAN)
                                                  : end_full[GCNT_W-1:0];
  assign first_full = in_req.addr >> GRAN_SHIFT;
  assign empty_nxt  = (first_full >= 32'(end_clamp));
  assign gran_nxt   = gran_r + GCNT_W'(1);

  assign cur_page      = gran_r[GRAN_IDX_W-1:GPP_W];
  assign chk_page_full = req_r.addr[31:PAGE_SHIFT];
  assign chk_page      = chk_page_full[PAGE_IDX_W-1:0];
  assign chk_offs      = req_r.addr[PAGE_SHIFT-1:GRAN_SHIFT];
  assign chk_oob       = (chk_page_full >= (32 - PAGE_SHIFT)'(PAGE_COUNT));
  assign tag_w         = req_r.tag[TAG_BITS-1:0];

  assign status.gran_done    = empty_r || (gran_r >= end_r);
  assign status.page_present = present_r[cur_page];
  assign status.clr_last     = (clr_r == {GPP_W{1'b1}});
  assign status.chk_hit      = !chk_oob && present_r[chk_page];

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      gran_r  <= first_full[GCNT_W-1:0];
      end_r   <= end_clamp;
      empty_r <= empty_nxt;
    end else if (cmd.set_write) begin
      gran_r <= gran_nxt;
    end
    if (cmd.clr_start) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + GPP_W'(1);
    end
    if (cmd.load) begin
      match_r <= 1'b0;
    end else if (cmd.chk_direct) begin
      match_r <= !chk_oob && (tag_w == '0);
    end else if (cmd.chk_cmp) begin
      match_r <= (ram_rdata == tag_w);
    end
  end

  // Control state: presence bits and access counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.drop) begin
        present_r <= '0;
      end else if (cmd.clr_start) begin
        present_r[cur_page] <= 1'b1;
      end
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.set_write || cmd.chk_cmp) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  assign ram_we    = cmd.set_write || cmd.clr_step;
  assign ram_waddr = cmd.clr_step ? GRAN_IDX_W'({cur_page, clr_r}) : gran_r[GRAN_IDX_W-1:0];
  assign ram_wdata = cmd.clr_step ? '0 : tag_w;
  assign ram_raddr = GRAN_IDX_W'({chk_page, chk_offs});

  tmts_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (TOTAL_GRAN)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_res.tag_match    = match_r;
  assign out_res.access_count = count_r;

  `ASSERT_NEXT(a_cnt_hold, !cmd.set_write && !cmd.chk_cmp && !cmd.cnt_clr, $stable(count_r), "counter moved without an access")
  `ASSERT_ALWAYS(a_write_present, !cmd.set_write || present_r[cur_page], "tag written to absent page")

endmodule

FILE: sim/tb.sv
// Self-checking bench for two_level_memory_tag_store: directed and random requests,
// each result checked against an in-bench model of presence bits, granule tags
// and the access counter. Depends on tmts_pkg and the RTL of the tag store.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmts_pkg::*;

  // Bytes covered by the tag store, and a small window of pages that most
  // random traffic stays in so that set and check requests hit each other.
  localparam int unsigned TAGGED_BYTES = PAGE_COUNT * PAGE_BYTES;
  localparam int unsigned WINDOW_BYTES = 16 * PAGE_BYTES;
  localparam logic [7:0]  TAG_MASK     = 8'((1 << TAG_BITS) - 1);
  // A full-range set walks every granule and clears every page; the limit sits far
  // above what the whole run needs, so it only trips on a hang.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          MAX_REPORTS  = 100;

  logic     clk    = 1'b0;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  out_res_t out_res;

  // Shadow copy of the store's state, advanced once per accepted request.
  bit               present_map [PAGE_COUNT];
  logic [7:0]       shadow_tags [TOTAL_GRAN];
  logic [CNT_W-1:0] shadow_count = '0;

  out_res_t    expected_results [$];
  int          mismatch_count  = 0;
  int          sender_idle_pct = 0;
  int unsigned cycle_count     = 0;

  two_level_memory_tag_store DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Count a mismatch; print only the first MAX_REPORTS so a broken block cannot flood the log.
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("error @%0t: %s", $realtime, msg);
  endtask

  // Append one prediction behind the ones still outstanding.
  task automatic queue_expected(out_res_t res);
    expected_results = {expected_results, res};
  endtask

  // Advance the shadow state by one request and return the result it must produce.
  function automatic out_res_t apply_request(in_req_t r);
    out_res_t         res;
    longint unsigned  g_first;
    longint unsigned  g_end;
    longint unsigned  page;
    longint unsigned  offs;
    logic [7:0]       tag;
    res = '0;
    tag = r.tag & TAG_MASK;
    case (r.req_type)
      REQ_SET: begin
        g_first = longint'(r.addr) / GRANULE_BYTES;
        g_end   = (longint'(r.addr) + longint'(r.range_size) + GRANULE_BYTES - 1)
                  / GRANULE_BYTES;
        // Clip at the end of the last page; skipped granules are not counted.
        if (g_end > TOTAL_GRAN) g_end = 64'(TOTAL_GRAN);
        for (longint unsigned g = g_first; g < g_end; g++) begin
          page = g / GRAN_PER_PG;
          // First touch of a page: mark it present and zero all its granules.
          if (!present_map[page]) begin
            present_map[page] = 1'b1;
            for (int k = 0; k < GRAN_PER_PG; k++) shadow_tags[page * GRAN_PER_PG + k] = '0;
          end
          shadow_tags[g] = tag;
          shadow_count++;
        end
      end
      REQ_CHECK: begin
        page = longint'(r.addr) / PAGE_BYTES;
        offs = (longint'(r.addr) % PAGE_BYTES) / GRANULE_BYTES;
        if (page >= PAGE_COUNT) begin
          res.tag_match = 1'b0;
        end else if (!present_map[page]) begin
          // An absent page reads as all zero tags and is not counted.
          res.tag_match = (tag == '0);
        end else begin
          shadow_count++;
          res.tag_match = ((shadow_tags[page * GRAN_PER_PG + offs] & TAG_MASK) == tag);
        end
      end
      REQ_DROP: begin
        foreach (present_map[i]) present_map[i] = 1'b0;
      end
      default: begin
        shadow_count = '0;
      end
    endcase
    res.access_count = shadow_count;
    return res;
  endfunction

  function automatic in_req_t make_req(logic [1:0] kind, logic [31:0] addr,
                                       logic [23:0] size, logic [7:0] tag);
    in_req_t r;
    r.req_type   = kind;
    r.addr       = addr;
    r.range_size = size;
    r.tag        = tag;
    return r;
  endfunction

  // Present one request and hold it until the block takes it. Start is left
  // high afterwards so back-to-back requests never drop it within one step.
  task automatic send_request(in_req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    queue_expected(apply_request(r));
  endtask

  // Compare every result strobe with the oldest outstanding prediction.
  always @(posedge clk) begin : result_checker
    out_res_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_res.tag_match !== want.tag_match)
          report_mismatch($sformatf("tag_match: expected %0b, got %0b",
                                    want.tag_match, out_res.tag_match));
        if (out_res.access_count !== want.access_count)
          report_mismatch($sformatf("access_count: expected %0h, got %0h",
                                    want.access_count, out_res.access_count));
      end
    end
  end

  // Checks of absent pages, and zero-length sets both unaligned and aligned.
  task automatic test_absent_and_zero_length();
    send_request(make_req(REQ_CHECK, 32'h0000_0000, 24'h0, 8'h00));
    send_request(make_req(REQ_CHECK, 32'h0000_0FFF, 24'hFFFFFF, 8'hFF));
    send_request(make_req(REQ_SET,   32'h0000_1003, 24'h0, 8'hA5));
    send_request(make_req(REQ_CHECK, 32'h0000_100F, 24'h0, 8'hA5));
    // Neighbor granule was zeroed when the page became present.
    send_request(make_req(REQ_CHECK, 32'h0000_1010, 24'h0, 8'h00));
    send_request(make_req(REQ_SET,   32'h0000_2000, 24'h0, 8'h5A));
    send_request(make_req(REQ_CHECK, 32'h0000_2000, 24'h0, 8'h00));
  endtask

  // Ranges across a page boundary, past the last page, and checks out of range.
  task automatic test_page_boundaries();
    send_request(make_req(REQ_SET,   32'h0000_1FF8, 24'h20, 8'h3C));
    send_request(make_req(REQ_CHECK, 32'h0000_2010, 24'h0, 8'h3C));
    send_request(make_req(REQ_CHECK, 32'h0000_2020, 24'h0, 8'h3C));
    send_request(make_req(REQ_SET,   32'h000F_FFF0, 24'h100, 8'hFF));
    send_request(make_req(REQ_CHECK, 32'h000F_FFF8, 24'h0, 8'hFF));
    send_request(make_req(REQ_CHECK, 32'h0010_0000, 24'h0, 8'h00));
    send_request(make_req(REQ_CHECK, 32'hFFFF_FFFF, 24'h0, 8'hFF));
    send_request(make_req(REQ_SET,   32'hFFFF_FFF0, 24'hFFFFFF, 8'h55));
  endtask

  // Free a block, drop every page, clear the counter.
  task automatic test_free_and_drop();
    send_request(make_req(REQ_SET,     32'h0000_1FF8, 24'h20, 8'h00));
    send_request(make_req(REQ_CHECK,   32'h0000_2000, 24'h0, 8'h00));
    send_request(make_req(REQ_DROP,    32'hFFFF_FFFF, 24'hFFFFFF, 8'hFF));
    send_request(make_req(REQ_CHECK,   32'h0000_100F, 24'h0, 8'hA5));
    send_request(make_req(REQ_CLR_CNT, 32'hFFFF_FFFF, 24'hFFFFFF, 8'hFF));
  endtask

  // One set over the whole store with the largest size, then leave it empty.
  task automatic test_full_range();
    send_request(make_req(REQ_SET,     32'h0000_0000, 24'hFFFFFF, 8'hC3));
    send_request(make_req(REQ_CHECK,   32'h0007_FFF0, 24'h0, 8'hC3));
    send_request(make_req(REQ_CHECK,   32'h000F_FFF0, 24'h0, 8'h3C));
    send_request(make_req(REQ_CLR_CNT, 32'h0, 24'h0, 8'h0));
    send_request(make_req(REQ_DROP,    32'h0, 24'h0, 8'h0));
  endtask

  // Mostly sets and checks inside a small window of pages, plus out-of-range
  // noise, last-page ranges, drops and counter clears.
  task automatic test_random_traffic(int idle_pct, int count);
    in_req_t     r;
    int          sel;
    int          size_sel;
    int unsigned a;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      sel          = $urandom_range(0, 99);
      r.req_type   = REQ_CHECK;
      r.addr       = $urandom;
      r.range_size = 24'($urandom);
      r.tag        = 8'($urandom);
      if (sel < 45) begin
        r.req_type = REQ_SET;
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TAGGED_BYTES - 1)
                                        : $urandom_range(0, WINDOW_BYTES - 1);
        r.addr   = a;
        size_sel = $urandom_range(0, 99);
        // Keep most ranges short; long walks plus page clears are slow.
        if (size_sel < 80)      r.range_size = 24'($urandom_range(0, 255));
        else if (size_sel < 98) r.range_size = 24'($urandom_range(0, 4095));
        else                    r.range_size = 24'($urandom_range(0, 65535));
        if ($urandom_range(0, 6) == 0) r.tag = '0;
      end else if (sel < 85) begin
        a = $urandom_range(0, WINDOW_BYTES - 1);
        r.addr = a;
        // Expect the stored tag most of the time so matches are common.
        if ($urandom_range(0, 9) < 6)
          r.tag = present_map[a / PAGE_BYTES] ? shadow_tags[a / GRANULE_BYTES] : '0;
      end else if (sel < 90) begin
        if ($urandom_range(0, 1) == 0) r.addr = $urandom_range(0, TAGGED_BYTES - 1);
      end else if (sel < 93) begin
        r.req_type = REQ_SET;
      end else if (sel < 95) begin
        r.req_type = REQ_SET;
        r.addr     = (PAGE_COUNT - 1) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
      end else if (sel < 97) begin
        r.req_type = REQ_DROP;
      end else begin
        r.req_type = REQ_CLR_CNT;
      end
      send_request(r);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 36;
    test_absent_and_zero_length();
    test_page_boundaries();
    test_free_and_drop();
    test_full_range();
    test_random_traffic(36, 630);
    test_random_traffic(78, 630);
    test_random_traffic(0, 640);

    // Release start, wait for every outstanding result, then watch for strays.
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
